// ===== rtl/rbs_pkg.sv =====
// rbs_pkg: shared types, constants and tables of the pose to state vector block
package rbs_pkg;

    // fixed-point formats
    localparam int POSITION_FRACTION_BITS = 16;
    localparam int ANGLE_FRACTION_BITS    = 13;

    localparam int CORDIC_STEPS = 18;
    localparam int ANG_W        = 24;

    localparam logic signed [ANG_W-1:0] ANG_PI_Q20      = 24'sd3294199;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [31:0]      ONE_Q28         = 32'sd268435456;
    localparam logic signed [15:0]      ONE_Q14         = 16'sd16384;
    localparam logic signed [29:0]      VEL_SCALE       = 30'sd1000000;
    localparam logic signed [29:0]      RATE_SCALE      = 30'sd2000000;

    // one input beat
    typedef struct packed {
        logic        [7:0]  body_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [23:0] elapsed_us;
    } sample_t;

    // one result beat
    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } result_t;

    // divide / square root unit
    typedef enum logic {
        DU_DIV,
        DU_SQRT
    } du_op_t;

    typedef struct packed {
        logic   start;
        du_op_t op;
    } du_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // arctangent of 2^-i in Q20
    function automatic logic [19:0] atan_q20(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/rigid_body_pose_to_state_vector_top.sv =====
// rigid_body_pose_to_state_vector_top: sequencer, shared multiplier and state of the block
//
// Takes tracked-body samples and, for the body selected by the target register, returns one
// beat with the position, finite-difference velocity, ZYX Euler angles and angular rate.
// A sample for another body is taken and dropped. No new sample is taken while a target
// sample is worked on: shared multiply-accumulate steps, three 18-step cordic runs, and
// above all the bit-serial divide / square root unit, which does up to ten divisions and
// two square roots. A finished result waits in its output register while the next sample
// is already being worked on.
module rigid_body_pose_to_state_vector_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  rbs_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output rbs_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ANG_SHIFT = 20 - rbs_pkg::ANGLE_FRACTION_BITS;
    localparam int RDEN_SHIFT = 28 - rbs_pkg::POSITION_FRACTION_BITS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM,
        S_NSQ,
        S_NSQW,
        S_UDIV,
        S_UDIVW,
        S_TERM,
        S_PSQ,
        S_PSQW,
        S_CORD,
        S_CORDW,
        S_HRND,
        S_QUAT,
        S_SCALE,
        S_VDIV,
        S_VDIVW,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [3:0]            idx_reg;
    logic                  ph_reg;
    logic [7:0]            target_reg;
    logic signed [31:0]    last_pos_reg [3];
    logic signed [15:0]    last_q_reg [4];
    logic                  result_valid_reg;
    rbs_pkg::result_t      result_reg;

    rbs_pkg::sample_t      smp_reg;
    logic [32:0]           n2_reg;
    logic [31:0]           r_reg;
    logic signed [29:0]    u_reg [4];
    logic signed [31:0]    tr_reg [5];
    logic [55:0]           ssq_reg;
    logic [31:0]           pq_reg;
    logic signed [15:0]    ang_out_reg [3];
    logic signed [15:0]    h_reg [4];
    logic signed [31:0]    vq_reg [3];
    logic signed [53:0]    num_reg [6];
    logic signed [31:0]    res_reg [6];
    logic signed [63:0]    prod_reg;
    logic signed [63:0]    acc_reg;

    logic signed [15:0]    q_v [4];
    logic signed [33:0]    mac_a;
    logic signed [29:0]    mac_b;
    logic                  mac_neg;
    logic                  mac_first;
    logic                  mac_last;
    logic                  mac_end;
    logic                  mac_on;
    logic signed [63:0]    prod_next;
    logic signed [63:0]    acc_new;

    rbs_pkg::du_req_t      du_req;
    logic [63:0]           du_a;
    logic [63:0]           du_b;
    rbs_pkg::unit_stat_t   du_stat;
    logic [63:0]           du_res;

    logic                  cd_start;
    logic signed [31:0]    cd_y;
    logic signed [31:0]    cd_x;
    logic signed [31:0]    cd_ys_arg;
    rbs_pkg::unit_stat_t   cd_stat;
    logic signed [rbs_pkg::ANG_W-1:0] cd_ang;
    logic signed [rbs_pkg::ANG_W-1:0] ang_pick;

    logic                  sample_take;
    logic                  out_free;
    logic                  el_zero;
    logic [15:0]           q_mag;
    logic [53:0]           num_mag;
    logic signed [29:0]    u_div;
    logic [63:0]           u_quo;
    logic signed [31:0]    sat_q;

    // round a Q20 angle to the output format and saturate
    function automatic logic signed [15:0] angle_out(input logic signed [rbs_pkg::ANG_W-1:0] a);
        logic signed [rbs_pkg::ANG_W:0] s;
        logic signed [rbs_pkg::ANG_W:0] r;
        logic signed [15:0]             o;
        s = (rbs_pkg::ANG_W+1)'(a) + ((rbs_pkg::ANG_W+1)'(1) <<< (ANG_SHIFT - 1));
        r = s >>> ANG_SHIFT;
        if (r > 32767)
            o = 16'sh7fff;
        else if (r < -32768)
            o = 16'sh8000;
        else
            o = 16'(r);
        return o;
    endfunction

    // round a Q28 component to Q14 and clamp to unit
    function automatic logic signed [15:0] round_q14(input logic signed [29:0] u);
        logic signed [30:0] s;
        logic signed [30:0] t;
        logic signed [15:0] o;
        s = 31'(u) + 31'sd8192;
        t = s >>> 14;
        if (t > 31'(rbs_pkg::ONE_Q14))
            o = rbs_pkg::ONE_Q14;
        else if (t < -31'(rbs_pkg::ONE_Q14))
            o = -rbs_pkg::ONE_Q14;
        else
            o = 16'(t);
        return o;
    endfunction

    assign q_v[0] = smp_reg.quat_w;
    assign q_v[1] = smp_reg.quat_x;
    assign q_v[2] = smp_reg.quat_y;
    assign q_v[3] = smp_reg.quat_z;

    assign sample_ready = (state_reg == S_IDLE);
    assign sample_take  = sample_valid && sample_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign el_zero      = (smp_reg.elapsed_us == 24'd0);

    // multiply-accumulate program: operands, sign and group marks
    always_comb
    begin
        mac_a     = '0;
        mac_b     = '0;
        mac_neg   = 1'b0;
        mac_first = 1'b0;
        mac_last  = 1'b0;
        mac_end   = 1'b0;
        mac_on    = 1'b0;
        case (state_reg)
            S_NORM:
            begin
                mac_on    = 1'b1;
                mac_a     = 34'(q_v[idx_reg[1:0]]);
                mac_b     = 30'(q_v[idx_reg[1:0]]);
                mac_first = (idx_reg == 4'd0);
                mac_last  = (idx_reg == 4'd3);
                mac_end   = mac_last;
            end
            S_TERM:
            begin
                mac_on = 1'b1;
                case (idx_reg)
                    4'd0:
                    begin
                        mac_a = 34'(u_reg[0]); mac_b = u_reg[1]; mac_first = 1'b1;
                    end
                    4'd1:
                    begin
                        mac_a = 34'(u_reg[2]); mac_b = u_reg[3]; mac_last = 1'b1;
                    end
                    4'd2:
                    begin
                        mac_a = 34'(u_reg[1]); mac_b = u_reg[1]; mac_first = 1'b1;
                    end
                    4'd3:
                    begin
                        mac_a = 34'(u_reg[2]); mac_b = u_reg[2]; mac_last = 1'b1;
                    end
                    4'd4:
                    begin
                        mac_a = 34'(u_reg[0]); mac_b = u_reg[2]; mac_first = 1'b1;
                    end
                    4'd5:
                    begin
                        mac_a = 34'(u_reg[3]); mac_b = u_reg[1]; mac_neg = 1'b1;
                        mac_last = 1'b1;
                    end
                    4'd6:
                    begin
                        mac_a = 34'(u_reg[0]); mac_b = u_reg[3]; mac_first = 1'b1;
                    end
                    4'd7:
                    begin
                        mac_a = 34'(u_reg[1]); mac_b = u_reg[2]; mac_last = 1'b1;
                    end
                    4'd8:
                    begin
                        mac_a = 34'(u_reg[2]); mac_b = u_reg[2]; mac_first = 1'b1;
                    end
                    4'd9:
                    begin
                        mac_a = 34'(u_reg[3]); mac_b = u_reg[3]; mac_last = 1'b1;
                    end
                    default:
                    begin
                        // square of the pitch sine, used only when it is below one
                        mac_a = 34'(tr_reg[2]); mac_b = tr_reg[2][29:0];
                        mac_first = 1'b1; mac_last = 1'b1; mac_end = 1'b1;
                    end
                endcase
            end
            S_QUAT:
            begin
                mac_on    = 1'b1;
                mac_first = (idx_reg[1:0] == 2'd0);
                mac_last  = (idx_reg[1:0] == 2'd3);
                mac_end   = (idx_reg == 4'd11);
                case (idx_reg)
                    4'd0:  begin mac_a = 34'(last_q_reg[0]); mac_b = 30'(h_reg[1]); end
                    4'd1:  begin mac_a = 34'(h_reg[0]); mac_b = 30'(last_q_reg[1]);
                                 mac_neg = 1'b1; end
                    4'd2:  begin mac_a = 34'(h_reg[2]); mac_b = 30'(last_q_reg[3]);
                                 mac_neg = 1'b1; end
                    4'd3:  begin mac_a = 34'(h_reg[3]); mac_b = 30'(last_q_reg[2]); end
                    4'd4:  begin mac_a = 34'(last_q_reg[0]); mac_b = 30'(h_reg[2]); end
                    4'd5:  begin mac_a = 34'(h_reg[0]); mac_b = 30'(last_q_reg[2]);
                                 mac_neg = 1'b1; end
                    4'd6:  begin mac_a = 34'(h_reg[3]); mac_b = 30'(last_q_reg[1]);
                                 mac_neg = 1'b1; end
                    4'd7:  begin mac_a = 34'(h_reg[1]); mac_b = 30'(last_q_reg[3]); end
                    4'd8:  begin mac_a = 34'(last_q_reg[0]); mac_b = 30'(h_reg[3]); end
                    4'd9:  begin mac_a = 34'(h_reg[0]); mac_b = 30'(last_q_reg[3]);
                                 mac_neg = 1'b1; end
                    4'd10: begin mac_a = 34'(h_reg[1]); mac_b = 30'(last_q_reg[2]);
                                 mac_neg = 1'b1; end
                    default: begin mac_a = 34'(h_reg[2]); mac_b = 30'(last_q_reg[1]); end
                endcase
            end
            S_SCALE:
            begin
                mac_on    = 1'b1;
                mac_first = 1'b1;
                mac_last  = 1'b1;
                mac_end   = (idx_reg == 4'd5);
                case (idx_reg)
                    4'd0:
                    begin
                        mac_a = 34'(33'(smp_reg.pos_x) - 33'(last_pos_reg[0]));
                        mac_b = rbs_pkg::VEL_SCALE;
                    end
                    4'd1:
                    begin
                        mac_a = 34'(33'(smp_reg.pos_y) - 33'(last_pos_reg[1]));
                        mac_b = rbs_pkg::VEL_SCALE;
                    end
                    4'd2:
                    begin
                        mac_a = 34'(33'(smp_reg.pos_z) - 33'(last_pos_reg[2]));
                        mac_b = rbs_pkg::VEL_SCALE;
                    end
                    4'd3:    begin mac_a = 34'(vq_reg[0]); mac_b = rbs_pkg::RATE_SCALE; end
                    4'd4:    begin mac_a = 34'(vq_reg[1]); mac_b = rbs_pkg::RATE_SCALE; end
                    default: begin mac_a = 34'(vq_reg[2]); mac_b = rbs_pkg::RATE_SCALE; end
                endcase
            end
            default:
            begin
                mac_on = 1'b0;
            end
        endcase
        prod_next = mac_a * mac_b;
        acc_new   = (mac_first ? 64'sd0 : acc_reg) + (mac_neg ? -prod_reg : prod_reg);
    end

    // operands of the divide / square root unit
    always_comb
    begin
        q_mag   = (q_v[idx_reg[1:0]] < 0) ? 16'(-q_v[idx_reg[1:0]]) : 16'(q_v[idx_reg[1:0]]);
        num_mag = (num_reg[idx_reg[2:0]] < 0) ? 54'(-num_reg[idx_reg[2:0]])
                                             : 54'(num_reg[idx_reg[2:0]]);
        du_req.start = 1'b0;
        du_req.op    = rbs_pkg::DU_DIV;
        du_a         = '0;
        du_b         = '0;
        case (state_reg)
            S_NSQ:
            begin
                du_req.start = (n2_reg != 33'd0);
                du_req.op    = rbs_pkg::DU_SQRT;
                du_a         = 64'(n2_reg) << 30;
            end
            S_UDIV:
            begin
                du_req.start = 1'b1;
                du_a         = 64'(q_mag) << 43;
                du_b         = 64'(r_reg);
            end
            S_PSQ:
            begin
                du_req.start = 1'b1;
                du_req.op    = rbs_pkg::DU_SQRT;
                du_a         = (64'd1 << 56) - 64'(ssq_reg);
            end
            S_VDIV:
            begin
                du_req.start = !el_zero;
                du_a         = 64'(num_mag);
                du_b         = (idx_reg < 4'd3) ? 64'(smp_reg.elapsed_us)
                                               : (64'(smp_reg.elapsed_us) << RDEN_SHIFT);
            end
            default:
            begin
                du_req.start = 1'b0;
            end
        endcase
    end

    // clamp and sign of a normalized component, saturation of a velocity
    always_comb
    begin
        u_quo = (du_res > 64'(rbs_pkg::ONE_Q28)) ? 64'(rbs_pkg::ONE_Q28) : du_res;
        u_div = (q_v[idx_reg[1:0]] < 0) ? -30'(u_quo) : 30'(u_quo);
        if (num_reg[idx_reg[2:0]] < 0)
            sat_q = (du_res > 64'h8000_0000) ? 32'sh8000_0000 : -32'(du_res);
        else
            sat_q = (du_res > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(du_res);
    end

    // cordic operands and pitch clamp
    always_comb
    begin
        cd_start  = (state_reg == S_CORD);
        cd_ys_arg = tr_reg[2];
        case (idx_reg[1:0])
            2'd0:    begin cd_y = tr_reg[0]; cd_x = tr_reg[1]; end
            2'd1:    begin cd_y = cd_ys_arg; cd_x = pq_reg; end
            default: begin cd_y = tr_reg[3]; cd_x = tr_reg[4]; end
        endcase
        ang_pick = cd_ang;
        if (idx_reg[1:0] == 2'd1)
        begin
            if (tr_reg[2] >= rbs_pkg::ONE_Q28)
                ang_pick = rbs_pkg::ANG_HALF_PI_Q20;
            else if (tr_reg[2] <= -rbs_pkg::ONE_Q28)
                ang_pick = -rbs_pkg::ANG_HALF_PI_Q20;
        end
    end

    rbs_divsqrt u_du (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (du_req),
        .a     (du_a),
        .b     (du_b),
        .stat  (du_stat),
        .res   (du_res)
    );

    rbs_cordic u_cd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .y_in  (cd_y),
        .x_in  (cd_x),
        .stat  (cd_stat),
        .ang   (cd_ang)
    );

    // sequencer, stored state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            ph_reg           <= 1'b0;
            target_reg       <= '0;
            last_pos_reg[0]  <= '0;
            last_pos_reg[1]  <= '0;
            last_pos_reg[2]  <= '0;
            last_q_reg[0]    <= rbs_pkg::ONE_Q14;
            last_q_reg[1]    <= '0;
            last_q_reg[2]    <= '0;
            last_q_reg[3]    <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && !paddr[2])
                target_reg <= pwdata[7:0];
            // a new beat loaded in S_DONE keeps valid high
            if (result_valid_reg && result_ready && state_reg != S_DONE)
                result_valid_reg <= 1'b0;

            if (mac_on)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                    idx_reg <= mac_end ? 4'd0 : idx_reg + 4'd1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    ph_reg  <= 1'b0;
                    if (sample_take && sample.body_id == target_reg)
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (ph_reg && mac_end)
                        state_reg <= S_NSQ;
                end
                S_NSQ:
                begin
                    state_reg <= (n2_reg == 33'd0) ? S_TERM : S_NSQW;
                end
                S_NSQW:
                begin
                    if (du_stat.done)
                        state_reg <= S_UDIV;
                end
                S_UDIV:
                begin
                    state_reg <= S_UDIVW;
                end
                S_UDIVW:
                begin
                    if (du_stat.done)
                    begin
                        if (idx_reg == 4'd3)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_TERM;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_UDIV;
                        end
                    end
                end
                S_TERM:
                begin
                    if (ph_reg && mac_end)
                        state_reg <= S_PSQ;
                end
                S_PSQ:
                begin
                    state_reg <= S_PSQW;
                end
                S_PSQW:
                begin
                    if (du_stat.done)
                        state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    state_reg <= S_CORDW;
                end
                S_CORDW:
                begin
                    if (cd_stat.done)
                    begin
                        if (idx_reg == 4'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_HRND;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_CORD;
                        end
                    end
                end
                S_HRND:
                begin
                    state_reg <= S_QUAT;
                end
                S_QUAT:
                begin
                    if (ph_reg && mac_end)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (ph_reg && mac_end)
                        state_reg <= S_VDIV;
                end
                S_VDIV:
                begin
                    if (!el_zero)
                        state_reg <= S_VDIVW;
                    else if (idx_reg == 4'd5)
                        state_reg <= S_DONE;
                    else
                        idx_reg <= idx_reg + 4'd1;
                end
                S_VDIVW:
                begin
                    if (du_stat.done)
                    begin
                        if (idx_reg == 4'd5)
                            state_reg <= S_DONE;
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_VDIV;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg.out_pos_x   <= smp_reg.pos_x;
                        result_reg.out_pos_y   <= smp_reg.pos_y;
                        result_reg.out_pos_z   <= smp_reg.pos_z;
                        result_reg.vel_x       <= res_reg[0];
                        result_reg.vel_y       <= res_reg[1];
                        result_reg.vel_z       <= res_reg[2];
                        result_reg.yaw_angle   <= ang_out_reg[2];
                        result_reg.pitch_angle <= ang_out_reg[1];
                        result_reg.roll_angle  <= ang_out_reg[0];
                        result_reg.rate_x      <= res_reg[3];
                        result_reg.rate_y      <= res_reg[4];
                        result_reg.rate_z      <= res_reg[5];
                        result_valid_reg       <= 1'b1;
                        last_pos_reg[0]        <= smp_reg.pos_x;
                        last_pos_reg[1]        <= smp_reg.pos_y;
                        last_pos_reg[2]        <= smp_reg.pos_z;
                        last_q_reg[0]          <= h_reg[0];
                        last_q_reg[1]          <= h_reg[1];
                        last_q_reg[2]          <= h_reg[2];
                        last_q_reg[3]          <= h_reg[3];
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (sample_take)
            smp_reg <= sample;

        // product in the first half step, accumulate and write back in the second
        if (mac_on && !ph_reg)
            prod_reg <= prod_next;
        if (mac_on && ph_reg)
        begin
            acc_reg <= acc_new;
            if (mac_last)
            begin
                case (state_reg)
                    S_NORM:
                    begin
                        n2_reg <= acc_new[32:0];
                    end
                    S_TERM:
                    begin
                        case (idx_reg)
                            4'd1:    tr_reg[0] <= 32'(acc_new >>> 27);
                            4'd3:    tr_reg[1] <= rbs_pkg::ONE_Q28 - 32'(acc_new >>> 27);
                            4'd5:    tr_reg[2] <= 32'(acc_new >>> 27);
                            4'd7:    tr_reg[3] <= 32'(acc_new >>> 27);
                            4'd9:    tr_reg[4] <= rbs_pkg::ONE_Q28 - 32'(acc_new >>> 27);
                            default: ssq_reg   <= acc_new[55:0];
                        endcase
                    end
                    S_QUAT:
                    begin
                        case (idx_reg[3:2])
                            2'd0:    vq_reg[0] <= 32'(acc_new);
                            2'd1:    vq_reg[1] <= 32'(acc_new);
                            default: vq_reg[2] <= 32'(acc_new);
                        endcase
                    end
                    default:
                    begin
                        num_reg[idx_reg[2:0]] <= acc_new[53:0];
                    end
                endcase
            end
        end

        // zero quaternion stands for the identity
        if (state_reg == S_NSQ && n2_reg == 33'd0)
        begin
            u_reg[0] <= 30'(rbs_pkg::ONE_Q28);
            u_reg[1] <= '0;
            u_reg[2] <= '0;
            u_reg[3] <= '0;
        end
        if (state_reg == S_NSQW && du_stat.done)
            r_reg <= du_res[31:0];
        if (state_reg == S_UDIVW && du_stat.done)
            u_reg[idx_reg[1:0]] <= u_div;
        if (state_reg == S_PSQW && du_stat.done)
            pq_reg <= du_res[31:0];
        if (state_reg == S_CORDW && cd_stat.done)
            ang_out_reg[idx_reg[1:0]] <= angle_out(ang_pick);
        if (state_reg == S_HRND)
        begin
            h_reg[0] <= round_q14(u_reg[0]);
            h_reg[1] <= round_q14(u_reg[1]);
            h_reg[2] <= round_q14(u_reg[2]);
            h_reg[3] <= round_q14(u_reg[3]);
        end
        // zero elapsed time gives zero velocity and rate
        if (state_reg == S_VDIV && el_zero)
            res_reg[idx_reg[2:0]] <= '0;
        if (state_reg == S_VDIVW && du_stat.done)
            res_reg[idx_reg[2:0]] <= sat_q;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign prdata       = paddr[2] ? 32'd0 : {24'd0, target_reg};

`ifndef ASSERT_OFF
    // the shared divide unit runs only while the sequencer waits on it
    a_du_wait: assert property (@(posedge clk) disable iff (!rst_n)
        du_stat.busy |-> (state_reg == S_NSQW || state_reg == S_UDIVW ||
                          state_reg == S_PSQW || state_reg == S_VDIVW))
        else $error("divide unit busy outside a wait state");

    // the cordic runs only while the sequencer waits on it
    a_cd_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cd_stat.busy |-> (state_reg == S_CORDW))
        else $error("cordic busy outside its wait state");

    // a sample for another body leaves the block idle
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_take && sample.body_id != target_reg) |=> (state_reg == S_IDLE))
        else $error("sample for another body was not dropped");

    // a result beat appears only when a sample finishes
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_DONE))
        else $error("result beat raised without a finished sample");
`endif

endmodule

// ===== rtl/rbs_divsqrt.sv =====
// rbs_divsqrt: bit-serial unsigned divider and integer square root
module rbs_divsqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  rbs_pkg::du_req_t    req,
    input  logic [63:0]         a,
    input  logic [63:0]         b,
    output rbs_pkg::unit_stat_t stat,
    output logic [63:0]         res
);

    logic                busy_reg;
    logic                done_reg;
    rbs_pkg::du_op_t     op_reg;
    logic [6:0]          cnt_reg;
    logic [63:0]         num_reg;
    logic [63:0]         den_reg;
    logic [65:0]         rem_reg;
    logic [63:0]         quo_reg;

    logic [65:0]         rem_sh;
    logic [65:0]         trial;
    logic                take;

    // one quotient or root bit per cycle
    always_comb
    begin
        if (op_reg == rbs_pkg::DU_DIV)
        begin
            rem_sh = {rem_reg[64:0], num_reg[63]};
            trial  = {2'b00, den_reg};
        end
        else
        begin
            rem_sh = {rem_reg[63:0], num_reg[63:62]};
            trial  = {quo_reg, 2'b01};
        end
        take = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == rbs_pkg::DU_DIV) ? 7'd63 : 7'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            num_reg <= a;
            den_reg <= b;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (rem_sh - trial) : rem_sh;
            quo_reg <= {quo_reg[62:0], take};
            num_reg <= (op_reg == rbs_pkg::DU_DIV) ? {num_reg[62:0], 1'b0}
                                                   : {num_reg[61:0], 2'b00};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = quo_reg;

endmodule

// ===== rtl/rbs_cordic.sv =====
// rbs_cordic: iterative vectoring cordic giving atan2 in Q20
module rbs_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [31:0]                  y_in,
    input  logic signed [31:0]                  x_in,
    output rbs_pkg::unit_stat_t                 stat,
    output logic signed [rbs_pkg::ANG_W-1:0]    ang
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [4:0]                        i_reg;
    logic signed [35:0]                x_reg;
    logic signed [35:0]                y_reg;
    logic signed [rbs_pkg::ANG_W-1:0]  ang_reg;

    logic                              neg;
    logic signed [35:0]                xs;
    logic signed [35:0]                ys;
    logic signed [rbs_pkg::ANG_W-1:0]  a0;
    logic signed [35:0]                sx;
    logic signed [35:0]                sy;
    logic signed [rbs_pkg::ANG_W-1:0]  at;

    // left half-plane fold on start
    always_comb
    begin
        neg = (x_in < 0);
        xs  = neg ? -36'(x_in) : 36'(x_in);
        ys  = neg ? -36'(y_in) : 36'(y_in);
        if (neg)
            a0 = (y_in >= 0) ? rbs_pkg::ANG_PI_Q20 : -rbs_pkg::ANG_PI_Q20;
        else
            a0 = '0;
        sx = x_reg >>> i_reg;
        sy = y_reg >>> i_reg;
        at = rbs_pkg::ANG_W'(rbs_pkg::atan_q20(i_reg));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg <= '0;
                if (ys == 0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(rbs_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rotation steps
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= xs;
            y_reg   <= ys;
            ang_reg <= a0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg   <= x_reg + sy;
                y_reg   <= y_reg - sx;
                ang_reg <= ang_reg + at;
            end
            else
            begin
                x_reg   <= x_reg - sy;
                y_reg   <= y_reg + sx;
                ang_reg <= ang_reg - at;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign ang       = ang_reg;

endmodule
